FILE: sv/segment_circle_intersect_xz_top_assert.svh
// Assertion macros for the segment/circle intersection top level.
`ifndef SEGMENT_CIRCLE_INTERSECT_XZ_TOP_ASSERT_SVH
`define SEGMENT_CIRCLE_INTERSECT_XZ_TOP_ASSERT_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define SCIZ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define SCIZ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/sciz_pkg.sv
// Shared widths, types and helpers for the segment/circle intersection pipeline.
package sciz_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int IN_W       = 32;
    localparam int RAD_W      = 31;
    localparam int EX_W       = IN_W + 1;
    localparam int A_W        = 2 * IN_W;
    localparam int H_W        = EX_W + IN_W + 1;
    localparam int C_W        = 2 * EX_W + 1;
    localparam int HM_W       = H_W - 1;
    localparam int CM_W       = C_W - 1;
    localparam int HL_W       = HM_W - IN_W;
    localparam int D_W        = 2 * HM_W;
    localparam int D2_W       = D_W + 1;
    localparam int S_W        = D_W / 2;
    localparam int SREM_W     = S_W + 2;
    localparam int NUM_W      = S_W + 2;
    localparam int NM_W       = NUM_W - 1;
    localparam int N_W        = NM_W + FRAC_BITS;
    localparam int Q_W        = 32;
    localparam int SQRT_STEPS = S_W;
    localparam int DIV_STEPS  = Q_W;
    localparam int DIV_LAT    = DIV_STEPS + 3;
    localparam int IN_PACK_W  = 6 * IN_W + RAD_W;
    localparam int S_TDATA_W  = ((IN_PACK_W + 7) / 8) * 8;
    localparam int OUT_PACK_W = 1 + 2 * Q_W;
    localparam int M_TDATA_W  = ((OUT_PACK_W + 7) / 8) * 8;

    localparam logic [Q_W-1:0] SAT_POS = {1'b0, {(Q_W-1){1'b1}}};
    localparam logic [Q_W-1:0] SAT_NEG = {1'b1, {(Q_W-1){1'b0}}};
    localparam logic [Q_W-2:0] UNIT    = (Q_W-1)'(1) << FRAC_BITS;

    typedef enum logic [1:0] {
        ST_REAL    = 2'd0,
        ST_NO_DISC = 2'd1,
        ST_DEGEN   = 2'd2
    } status_t;

    typedef struct packed {
        logic                  valid;
        status_t               status;
        logic signed [H_W-1:0] h;
        logic [A_W-1:0]        a;
    } side_t;

    typedef struct packed {
        logic                  hit;
        status_t               status;
        logic signed [Q_W-1:0] root_plus;
        logic signed [Q_W-1:0] root_minus;
    } result_t;

    // True when a root lies strictly between zero and one.
    function automatic logic in_unit(input logic signed [Q_W-1:0] r);
        return !r[Q_W-1] && (r != '0) && (r[Q_W-2:0] < UNIT);
    endfunction

endpackage

FILE: sv/sciz_quad.sv
// Quadratic setup stages: forms a, half b, c and the discriminant.
module sciz_quad (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              en,
    input  logic                              in_valid,
    input  logic signed [sciz_pkg::IN_W-1:0]  origin_x,
    input  logic signed [sciz_pkg::IN_W-1:0]  origin_z,
    input  logic signed [sciz_pkg::IN_W-1:0]  dir_x,
    input  logic signed [sciz_pkg::IN_W-1:0]  dir_z,
    input  logic signed [sciz_pkg::IN_W-1:0]  center_x,
    input  logic signed [sciz_pkg::IN_W-1:0]  center_z,
    input  logic        [sciz_pkg::RAD_W-1:0] radius,
    output logic        [sciz_pkg::D_W-1:0]   d_out,
    output sciz_pkg::side_t                   side_out
);
    import sciz_pkg::*;

    // stage 1
    logic                   v1_reg;
    logic signed [EX_W-1:0] ex1_reg, ez1_reg;
    logic signed [IN_W-1:0] dx1_reg, dz1_reg;
    logic [RAD_W-1:0]       rad1_reg;
    // stage 2
    logic                           v2_reg;
    logic [A_W-1:0]                 dxx2_reg, dzz2_reg;
    logic signed [EX_W+IN_W-1:0]    exdx2_reg, ezdz2_reg;
    logic [2*EX_W-2:0]              exex2_reg, ezez2_reg;
    logic [2*RAD_W-1:0]             rr2_reg;
    // stage 3
    logic                  v3_reg;
    logic [A_W-1:0]        a3_reg;
    logic signed [H_W-1:0] h3_reg;
    logic signed [C_W-1:0] c3_reg;
    // stage 4
    logic                  v4_reg;
    status_t               st4_reg;
    logic [HM_W-1:0]       hm4_reg;
    logic [CM_W-1:0]       cm4_reg;
    logic                  cneg4_reg;
    logic signed [H_W-1:0] h4_reg;
    logic [A_W-1:0]        a4_reg;
    // stage 5
    logic                   v5_reg;
    status_t                st5_reg;
    logic [2*HL_W-1:0]      p0_5_reg;
    logic [HL_W+IN_W-1:0]   p1_5_reg;
    logic [2*IN_W-1:0]      p2_5_reg;
    logic [IN_W+HL_W-1:0]   q0_5_reg, q1_5_reg, q2_5_reg, q3_5_reg;
    logic                   cneg5_reg;
    logic signed [H_W-1:0]  h5_reg;
    logic [A_W-1:0]         a5_reg;
    // stage 6
    logic                  v6_reg;
    status_t               st6_reg;
    logic [D2_W-1:0]       hsq6_reg, ac6_reg;
    logic                  cneg6_reg;
    logic signed [H_W-1:0] h6_reg;
    logic [A_W-1:0]        a6_reg;
    // stage 7
    logic                  v7_reg;
    status_t               st7_reg;
    logic [D_W-1:0]        d7_reg;
    logic signed [H_W-1:0] h7_reg;
    logic [A_W-1:0]        a7_reg;

    logic signed [2*IN_W-1:0]    dxx_next, dzz_next;
    logic signed [EX_W+IN_W-1:0] exdx_next, ezdz_next;
    logic signed [2*EX_W-1:0]    exex_next, ezez_next;
    logic [2*RAD_W-1:0]          rr_next;
    logic [A_W-1:0]              a_next;
    logic signed [H_W-1:0]       h_next, habs_next;
    logic signed [C_W-1:0]       c_next, cabs_next;
    logic [HL_W-1:0]             hl_next, cl_next;
    logic [IN_W-1:0]             hh_next, al_next, ah_next;
    logic [CM_W-HL_W-1:0]        ch_next;
    logic [D2_W-1:0]             hsq_next, ac_next;
    logic signed [D2_W-1:0]      dsum_next;
    status_t                     st7_next;

    // products of the offsets and direction
    assign dxx_next  = dx1_reg * dx1_reg;
    assign dzz_next  = dz1_reg * dz1_reg;
    assign exdx_next = ex1_reg * dx1_reg;
    assign ezdz_next = ez1_reg * dz1_reg;
    assign exex_next = ex1_reg * ex1_reg;
    assign ezez_next = ez1_reg * ez1_reg;
    assign rr_next   = rad1_reg * rad1_reg;

    // quadratic coefficients
    assign a_next = dxx2_reg + dzz2_reg;
    assign h_next = H_W'(exdx2_reg) + H_W'(ezdz2_reg);
    assign c_next = $signed({2'b00, exex2_reg}) + $signed({2'b00, ezez2_reg})
                  - $signed(C_W'(rr2_reg));

    // magnitudes for the wide squares
    assign habs_next = h3_reg[H_W-1] ? -h3_reg : h3_reg;
    assign cabs_next = c3_reg[C_W-1] ? -c3_reg : c3_reg;

    // split operands into partial product limbs
    assign hl_next = hm4_reg[HL_W-1:0];
    assign hh_next = hm4_reg[HM_W-1:HL_W];
    assign cl_next = cm4_reg[HL_W-1:0];
    assign ch_next = cm4_reg[CM_W-1:HL_W];
    assign al_next = a4_reg[IN_W-1:0];
    assign ah_next = a4_reg[A_W-1:IN_W];

    // sum the partial products
    assign hsq_next = D2_W'(p0_5_reg) + (D2_W'(p1_5_reg) << (HL_W + 1))
                    + (D2_W'(p2_5_reg) << (2 * HL_W));
    assign ac_next  = D2_W'(q0_5_reg) + (D2_W'(q1_5_reg) << HL_W)
                    + (D2_W'(q2_5_reg) << IN_W) + (D2_W'(q3_5_reg) << (IN_W + HL_W));

    // discriminant h^2 - a*c and its classification
    assign dsum_next = $signed(hsq6_reg) + (cneg6_reg ? $signed(ac6_reg) : -$signed(ac6_reg));
    always_comb begin
        if (st6_reg == ST_DEGEN) begin
            st7_next = ST_DEGEN;
        end else if (dsum_next[D2_W-1]) begin
            st7_next = ST_NO_DISC;
        end else begin
            st7_next = ST_REAL;
        end
    end

    // control: valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (en) begin
            ex1_reg   <= EX_W'(origin_x) - EX_W'(center_x);
            ez1_reg   <= EX_W'(origin_z) - EX_W'(center_z);
            dx1_reg   <= dir_x;
            dz1_reg   <= dir_z;
            rad1_reg  <= radius;

            dxx2_reg  <= dxx_next;
            dzz2_reg  <= dzz_next;
            exdx2_reg <= exdx_next;
            ezdz2_reg <= ezdz_next;
            exex2_reg <= exex_next[2*EX_W-2:0];
            ezez2_reg <= ezez_next[2*EX_W-2:0];
            rr2_reg   <= rr_next;

            a3_reg    <= a_next;
            h3_reg    <= h_next;
            c3_reg    <= c_next;

            st4_reg   <= (a3_reg == '0) ? ST_DEGEN : ST_REAL;
            hm4_reg   <= habs_next[HM_W-1:0];
            cm4_reg   <= cabs_next[CM_W-1:0];
            cneg4_reg <= c3_reg[C_W-1];
            h4_reg    <= h3_reg;
            a4_reg    <= a3_reg;

            st5_reg   <= st4_reg;
            p0_5_reg  <= hl_next * hl_next;
            p1_5_reg  <= hl_next * hh_next;
            p2_5_reg  <= hh_next * hh_next;
            q0_5_reg  <= al_next * cl_next;
            q1_5_reg  <= al_next * ch_next;
            q2_5_reg  <= ah_next * cl_next;
            q3_5_reg  <= ah_next * ch_next;
            cneg5_reg <= cneg4_reg;
            h5_reg    <= h4_reg;
            a5_reg    <= a4_reg;

            st6_reg   <= st5_reg;
            hsq6_reg  <= hsq_next;
            ac6_reg   <= ac_next;
            cneg6_reg <= cneg5_reg;
            h6_reg    <= h5_reg;
            a6_reg    <= a5_reg;

            st7_reg   <= st7_next;
            d7_reg    <= (st7_next == ST_REAL) ? dsum_next[D_W-1:0] : '0;
            h7_reg    <= h6_reg;
            a7_reg    <= a6_reg;
        end
    end

    assign d_out             = d7_reg;
    assign side_out.valid    = v7_reg;
    assign side_out.status   = st7_reg;
    assign side_out.h        = h7_reg;
    assign side_out.a        = a7_reg;

endmodule

FILE: sv/sciz_isqrt.sv
// Pipelined integer square root, one result bit per stage.
module sciz_isqrt (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         en,
    input  logic [sciz_pkg::D_W-1:0]     in_d,
    input  sciz_pkg::side_t              in_side,
    output logic [sciz_pkg::S_W-1:0]     out_s,
    output sciz_pkg::side_t              out_side
);
    import sciz_pkg::*;

    logic [D_W-1:0]    dsh_reg  [SQRT_STEPS];
    logic [SREM_W-1:0] rem_reg  [SQRT_STEPS];
    logic [S_W-1:0]    root_reg [SQRT_STEPS];
    side_t             side_reg [SQRT_STEPS];

    logic [D_W-1:0]    dsh_next  [SQRT_STEPS];
    logic [SREM_W-1:0] rem_next  [SQRT_STEPS];
    logic [S_W-1:0]    root_next [SQRT_STEPS];
    side_t             side_next [SQRT_STEPS];

    // one restoring step per stage: bring down two bits, try root*4+1
    always_comb begin
        logic [D_W-1:0]      d_prev;
        logic [SREM_W-1:0]   rem_prev;
        logic [S_W-1:0]      root_prev;
        logic [SREM_W+1:0]   cat;
        logic [SREM_W+1:0]   trial;
        logic                ge;
        for (int i = 0; i < SQRT_STEPS; i++) begin
            if (i == 0) begin
                d_prev       = in_d;
                rem_prev     = '0;
                root_prev    = '0;
                side_next[i] = in_side;
            end else begin
                d_prev       = dsh_reg[i-1];
                rem_prev     = rem_reg[i-1];
                root_prev    = root_reg[i-1];
                side_next[i] = side_reg[i-1];
            end
            cat          = {rem_prev, d_prev[D_W-1 -: 2]};
            trial        = (SREM_W+2)'({root_prev, 2'b01});
            ge           = (cat >= trial);
            rem_next[i]  = ge ? SREM_W'(cat - trial) : SREM_W'(cat);
            root_next[i] = {root_prev[S_W-2:0], ge};
            dsh_next[i]  = d_prev << 2;
        end
    end

    // advance all stages together
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < SQRT_STEPS; i++) begin
                side_reg[i].valid <= 1'b0;
            end
        end else if (en) begin
            for (int i = 0; i < SQRT_STEPS; i++) begin
                dsh_reg[i]  <= dsh_next[i];
                rem_reg[i]  <= rem_next[i];
                root_reg[i] <= root_next[i];
                side_reg[i] <= side_next[i];
            end
        end
    end

    assign out_s    = root_reg[SQRT_STEPS-1];
    assign out_side = side_reg[SQRT_STEPS-1];

endmodule

FILE: sv/sciz_div.sv
// Pipelined restoring divider that divides a root numerator, shifted up by FRAC_BITS, by a and saturates.
module sciz_div (
    input  logic                             aclk,
    input  logic                             en,
    input  logic signed [sciz_pkg::NUM_W-1:0] num,
    input  logic        [sciz_pkg::A_W-1:0]   a,
    output logic signed [sciz_pkg::Q_W-1:0]   root
);
    import sciz_pkg::*;

    // magnitude stage
    logic              neg0_reg;
    logic [NM_W-1:0]   mag0_reg;
    logic [A_W-1:0]    a0_reg;
    // range check stage
    logic              neg1_reg, big1_reg;
    logic [A_W-1:0]    rem1_reg, a1_reg;
    logic [Q_W-1:0]    low1_reg;
    // quotient bit stages
    logic              neg_reg  [DIV_STEPS];
    logic              big_reg  [DIV_STEPS];
    logic [A_W-1:0]    rem_reg  [DIV_STEPS];
    logic [A_W-1:0]    a_reg    [DIV_STEPS];
    logic [Q_W-1:0]    low_reg  [DIV_STEPS];
    logic [Q_W-1:0]    q_reg    [DIV_STEPS];
    // saturated result
    logic signed [Q_W-1:0] root_reg;

    logic signed [NUM_W-1:0] abs_next;
    logic [N_W-1:0]          n_next;
    logic [N_W-Q_W-1:0]      top_next;
    logic                    big_next;
    logic [A_W-1:0]          rem_next [DIV_STEPS];
    logic [Q_W-1:0]          low_next [DIV_STEPS];
    logic [Q_W-1:0]          q_next   [DIV_STEPS];
    logic [Q_W-1:0]          qf;
    logic signed [Q_W-1:0]   root_next;

    assign abs_next = num[NUM_W-1] ? -num : num;

    // quotient at or above 2^Q_W saturates either way
    assign n_next   = {mag0_reg, {FRAC_BITS{1'b0}}};
    assign top_next = n_next[N_W-1:Q_W];
    assign big_next = (A_W'(top_next) >= a0_reg);

    // one quotient bit per stage
    always_comb begin
        logic [A_W-1:0] rem_prev;
        logic [Q_W-1:0] low_prev;
        logic [Q_W-1:0] q_prev;
        logic [A_W-1:0] a_prev;
        logic [A_W:0]   cat;
        logic           ge;
        for (int i = 0; i < DIV_STEPS; i++) begin
            if (i == 0) begin
                rem_prev = rem1_reg;
                low_prev = low1_reg;
                q_prev   = '0;
                a_prev   = a1_reg;
            end else begin
                rem_prev = rem_reg[i-1];
                low_prev = low_reg[i-1];
                q_prev   = q_reg[i-1];
                a_prev   = a_reg[i-1];
            end
            cat         = {rem_prev, low_prev[Q_W-1]};
            ge          = (cat >= {1'b0, a_prev});
            rem_next[i] = ge ? A_W'(cat - {1'b0, a_prev}) : A_W'(cat);
            low_next[i] = low_prev << 1;
            q_next[i]   = {q_prev[Q_W-2:0], ge};
        end
    end

    // sign and saturate the quotient
    assign qf = q_reg[DIV_STEPS-1];
    always_comb begin
        if (neg_reg[DIV_STEPS-1]) begin
            if (big_reg[DIV_STEPS-1] || (qf > SAT_NEG)) begin
                root_next = $signed(SAT_NEG);
            end else begin
                root_next = $signed(-qf);
            end
        end else begin
            if (big_reg[DIV_STEPS-1] || qf[Q_W-1]) begin
                root_next = $signed(SAT_POS);
            end else begin
                root_next = $signed(qf);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            neg0_reg <= num[NUM_W-1];
            mag0_reg <= abs_next[NM_W-1:0];
            a0_reg   <= a;

            neg1_reg <= neg0_reg;
            big1_reg <= big_next;
            rem1_reg <= big_next ? '0 : A_W'(top_next);
            low1_reg <= n_next[Q_W-1:0];
            a1_reg   <= a0_reg;

            for (int i = 0; i < DIV_STEPS; i++) begin
                rem_reg[i] <= rem_next[i];
                low_reg[i] <= low_next[i];
                q_reg[i]   <= q_next[i];
                neg_reg[i] <= (i == 0) ? neg1_reg : neg_reg[(i == 0) ? 0 : i-1];
                big_reg[i] <= (i == 0) ? big1_reg : big_reg[(i == 0) ? 0 : i-1];
                a_reg[i]   <= (i == 0) ? a1_reg   : a_reg[(i == 0) ? 0 : i-1];
            end

            root_reg <= root_next;
        end
    end

    assign root = root_reg;

endmodule

FILE: sv/segment_circle_intersect_xz_top.sv
// Top level of the pipelined segment versus circle intersection unit (XZ plane).
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+----------------------------------------------
//  s_      | in  | s_tvalid/s_tready  | tdata: origin, dir, center, radius
//  m_      | out | m_tvalid/m_tready  | tdata: hit, root_plus, root_minus; tuser: status
//
//  One request is accepted per cycle while the skid register is empty; a result
//  passes through 109 register stages, with the first loaded at the accepting
//  edge: 7 setup stages, 65 square root stages, one numerator stage, 35
//  divider stages and the output register.
//  Reset (aresetn low, synchronous) clears all valid bits and the output side.
//  The whole pipeline advances while the skid register is empty; a stalled
//  result parks in the skid register, which freezes the pipeline and the input
//  until the output register takes it.
module segment_circle_intersect_xz_top (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // origin_x, origin_z, dir_x, dir_z, center_x, center_z, radius, zero pad
    input  logic [sciz_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // hit, root_plus, root_minus, zero pad
    output logic [sciz_pkg::M_TDATA_W-1:0]   m_tdata,
    // status
    output logic [1:0]                       m_tuser
);
    import sciz_pkg::*;

    localparam int CHAIN = DIV_LAT + 1;

    logic                   adv;
    logic [D_W-1:0]         quad_d;
    side_t                  quad_side;
    logic [S_W-1:0]         sq_s;
    side_t                  sq_side;
    logic signed [NUM_W-1:0] np_reg, nm_reg;
    logic [A_W-1:0]         na_reg;
    logic [CHAIN-1:0]       cv_reg;
    status_t                cst_reg [CHAIN];
    logic signed [Q_W-1:0]  rp_div, rm_div;
    result_t                res_next;
    logic                   res_valid;
    result_t                m_reg, skid_reg;
    logic                   m_v_reg, skid_v_reg;
    logic                   take_out;

    // the pipeline moves while the skid register is free
    assign adv      = !skid_v_reg;
    assign s_tready = adv;

    sciz_quad u_quad (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (adv),
        .in_valid (s_tvalid),
        .origin_x (s_tdata[IN_W-1:0]),
        .origin_z (s_tdata[2*IN_W-1:IN_W]),
        .dir_x    (s_tdata[3*IN_W-1:2*IN_W]),
        .dir_z    (s_tdata[4*IN_W-1:3*IN_W]),
        .center_x (s_tdata[5*IN_W-1:4*IN_W]),
        .center_z (s_tdata[6*IN_W-1:5*IN_W]),
        .radius   (s_tdata[IN_PACK_W-1:6*IN_W]),
        .d_out    (quad_d),
        .side_out (quad_side)
    );

    sciz_isqrt u_isqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (adv),
        .in_d     (quad_d),
        .in_side  (quad_side),
        .out_s    (sq_s),
        .out_side (sq_side)
    );

    // numerators -h + s and -h - s, status chain alongside the dividers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cv_reg <= '0;
        end else if (adv) begin
            cv_reg <= {cv_reg[CHAIN-2:0], sq_side.valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            np_reg <= -NUM_W'(sq_side.h) + $signed(NUM_W'(sq_s));
            nm_reg <= -NUM_W'(sq_side.h) - $signed(NUM_W'(sq_s));
            na_reg <= sq_side.a;
            for (int i = 0; i < CHAIN; i++) begin
                cst_reg[i] <= (i == 0) ? sq_side.status : cst_reg[(i == 0) ? 0 : i-1];
            end
        end
    end

    sciz_div u_div_plus (
        .aclk (aclk),
        .en   (adv),
        .num  (np_reg),
        .a    (na_reg),
        .root (rp_div)
    );

    sciz_div u_div_minus (
        .aclk (aclk),
        .en   (adv),
        .num  (nm_reg),
        .a    (na_reg),
        .root (rm_div)
    );

    // zero the roots unless real, flag a hit inside the unit interval
    assign res_valid = cv_reg[CHAIN-1];
    always_comb begin
        res_next.status = cst_reg[CHAIN-1];
        if (cst_reg[CHAIN-1] == ST_REAL) begin
            res_next.root_plus  = rp_div;
            res_next.root_minus = rm_div;
            res_next.hit        = in_unit(rp_div) || in_unit(rm_div);
        end else begin
            res_next.root_plus  = '0;
            res_next.root_minus = '0;
            res_next.hit        = 1'b0;
        end
    end

    // output register with one skid entry
    assign take_out = !m_v_reg || m_tready;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_v_reg    <= 1'b0;
            skid_v_reg <= 1'b0;
        end else if (take_out) begin
            if (skid_v_reg) begin
                m_reg      <= skid_reg;
                m_v_reg    <= 1'b1;
                skid_v_reg <= 1'b0;
            end else if (adv && res_valid) begin
                m_reg   <= res_next;
                m_v_reg <= 1'b1;
            end else begin
                m_v_reg <= 1'b0;
            end
        end else if (adv && res_valid) begin
            skid_reg   <= res_next;
            skid_v_reg <= 1'b1;
        end
    end

    assign m_tvalid = m_v_reg;
    assign m_tdata  = M_TDATA_W'({m_reg.root_minus, m_reg.root_plus, m_reg.hit});
    assign m_tuser  = m_reg.status;

`include "segment_circle_intersect_xz_top_assert.svh"

    `SCIZ_ASSERT_NOW(a_skid_needs_out, skid_v_reg, m_v_reg, "skid entry held with empty output")
    `SCIZ_ASSERT_NOW(a_skid_blocks_in, skid_v_reg, !s_tready, "request taken while skid is full")
    `SCIZ_ASSERT_NEXT(a_skid_drains, skid_v_reg && m_tready, !skid_v_reg, "skid entry not drained")
    `SCIZ_ASSERT_NOW(a_hit_real, m_tvalid && m_tdata[0], m_tuser == ST_REAL, "hit without real roots")
    `SCIZ_ASSERT_NOW(a_zero_roots, m_tvalid && (m_tuser != ST_REAL), m_tdata[OUT_PACK_W-1:0] == '0, "roots not cleared")

endmodule

FILE: verif/segment_circle_intersect_xz_top_tb.sv
// Self-checking testbench for the segment/circle intersection unit (XZ plane).
`timescale 1ns / 1ps

module segment_circle_intersect_xz_top_tb;
    import sciz_pkg::*;

    localparam int N_RANDOM    = 1100;
    localparam int DRAIN_AT    = 600;
    localparam int HOLD_START  = 400;
    localparam int HOLD_LEN    = 400;
    localparam int IDLE_LIMIT  = 5000;
    localparam int END_WAIT    = 150;
    localparam logic signed [31:0] ONE = 32'sd65536;

    typedef struct {
        logic signed [31:0] ox;
        logic signed [31:0] oz;
        logic signed [31:0] dx;
        logic signed [31:0] dz;
        logic signed [31:0] cx;
        logic signed [31:0] cz;
        logic [30:0]        radius;
    } segment_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [1:0]           m_tuser;

    segment_t pending_q[$];
    segment_t cur_seg;
    result_t  hit_expect_q[$];
    int       errors;
    int       sent_cnt;
    int       cycle_cnt;
    int       idle_cnt;
    int       burst_left;
    int       gap_left;
    int       stall_mode;
    logic     s_acc;
    bit       stim_done;

    segment_circle_intersect_xz_top u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Floor square root of a nonnegative wide value, bit by bit.
    function automatic logic signed [159:0] isqrt(input logic signed [159:0] v);
        logic signed [159:0] res;
        logic signed [159:0] t;
        res = '0;
        for (int i = 79; i >= 0; i--) begin
            t = res | (160'sd1 <<< i);
            if (t * t <= v) res = t;
        end
        return res;
    endfunction

    // Truncated quotient num * 2^16 / a, saturated to signed 32 bits.
    function automatic logic [31:0] scaled_root(input logic signed [159:0] num,
                                                input logic signed [159:0] a);
        logic signed [159:0] mag;
        logic signed [159:0] q;
        mag = (num < 0) ? -num : num;
        q = (mag <<< FRAC_BITS) / a;
        if (num < 0) begin
            if (q > 160'sd2147483648) return SAT_NEG;
            return 32'(-q);
        end
        if (q > 160'sd2147483647) return SAT_POS;
        return 32'(q);
    endfunction

    function automatic bit strictly_unit(input logic signed [31:0] r);
        return (r > 0) && (r < ONE);
    endfunction

    // Quadratic a t^2 + 2h t + c with exact wide intermediates.
    function automatic result_t predict_hit(input segment_t sg);
        result_t r;
        logic signed [159:0] ex, ez, dx, dz, rr, a, h, c, d, s;
        r = '{hit: 1'b0, status: ST_REAL, root_plus: '0, root_minus: '0};
        ex = 160'(sg.ox) - 160'(sg.cx);
        ez = 160'(sg.oz) - 160'(sg.cz);
        dx = 160'(sg.dx);
        dz = 160'(sg.dz);
        rr = $signed({129'd0, sg.radius});
        a = dx * dx + dz * dz;
        if (a == 0) begin
            r.status = ST_DEGEN;
            return r;
        end
        h = ex * dx + ez * dz;
        c = ex * ex + ez * ez - rr * rr;
        d = h * h - a * c;
        if (d < 0) begin
            r.status = ST_NO_DISC;
            return r;
        end
        s = isqrt(d);
        r.root_plus  = scaled_root(-h + s, a);
        r.root_minus = scaled_root(-h - s, a);
        r.hit = strictly_unit(r.root_plus) || strictly_unit(r.root_minus);
        return r;
    endfunction

    function automatic segment_t mk(input int ox, oz, dx, dz, cx, cz,
                                    input logic [30:0] rad);
        segment_t sg;
        sg = '{ox: ox, oz: oz, dx: dx, dz: dz, cx: cx, cz: cz, radius: rad};
        return sg;
    endfunction

    function automatic logic [31:0] rnd_coord(input int sel);
        logic [31:0] v;
        case (sel)
            0:       v = $urandom;
            1:       v = 32'($signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000);
            default: v = 32'($signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
        endcase
        return v;
    endfunction

    // Build the request list: directed corners first, then mostly small geometry.
    initial begin
        segment_t sg;
        int k;
        pending_q.push_back(mk(0, 0, 0, 0, 0, 0, 31'd0));
        pending_q.push_back(mk(32'h7fffffff, 32'h80000000, 0, 0, 5, 5, 31'h7fffffff));
        pending_q.push_back(mk(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                               32'h80000000, 32'h80000000, 31'h7fffffff));
        pending_q.push_back(mk(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                               32'h7fffffff, 32'h7fffffff, 31'd0));
        pending_q.push_back(mk(32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000,
                               32'h7fffffff, 32'h80000000, 31'h7fffffff));
        pending_q.push_back(mk(0, 0, 1, 0, 0, 0, 31'h7fffffff));
        pending_q.push_back(mk(0, 0, 32'h80000000, 0, 0, 0, 31'd1));
        // Crossing through the center, tangent and miss.
        pending_q.push_back(mk(-2 * ONE, 0, 4 * ONE, 0, 0, 0, 31'(ONE)));
        pending_q.push_back(mk(-2 * ONE, ONE, 4 * ONE, 0, 0, 0, 31'(ONE)));
        pending_q.push_back(mk(-2 * ONE, 3 * ONE, 4 * ONE, 0, 0, 0, 31'(ONE)));
        // Roots outside the unit interval, behind and ahead.
        pending_q.push_back(mk(2 * ONE, 0, ONE / 4, 0, 0, 0, 31'(ONE / 2)));
        pending_q.push_back(mk(-9 * ONE, 0, ONE / 4, 0, 0, 0, 31'(ONE)));
        pending_q.push_back(mk(0, 0, 0, ONE, 0, 0, 31'(ONE / 2)));
        pending_q.push_back(mk(0, 0, 1, 1, 32'h7fffffff, 32'h7fffffff, 31'h7fffffff));
        pending_q.push_back(mk(ONE, ONE, -ONE, -ONE, 0, 0, 31'd0));
        for (k = 0; k < N_RANDOM; k++) begin
            int sel;
            sel = (k % 8 == 0) ? 0 : ((k % 3 == 0) ? 1 : 2);
            sg.ox = rnd_coord(sel);
            sg.oz = rnd_coord(sel);
            sg.dx = rnd_coord(sel);
            sg.dz = rnd_coord(sel);
            sg.cx = rnd_coord(sel);
            sg.cz = rnd_coord(sel);
            sg.radius = (sel == 0) ? 31'($urandom) : 31'($urandom_range(0, 32'h0006_0000));
            if ($urandom_range(0, 40) == 0) begin
                sg.dx = '0;
                sg.dz = '0;
            end
            pending_q.push_back(sg);
        end
    end

    // Reset once, then wait for the stimulus to drain and the pipe to settle.
    initial begin
        errors = 0;
        stim_done = 1'b0;
        aresetn = 1'b0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        wait (pending_q.size() == 0 && !s_tvalid && hit_expect_q.size() == 0);
        repeat (END_WAIT) @(posedge aclk);
        stim_done = 1'b1;
        if (errors == 0 && hit_expect_q.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Note the request handshake for the driver.
    always @(posedge aclk) begin
        s_acc <= s_tvalid && s_tready;
    end

    // Driver: bursts with random gaps, one pause until all results are back.
    initial begin
        s_tvalid = 1'b0;
        s_tdata = '0;
        sent_cnt = 0;
        burst_left = 0;
        gap_left = 0;
    end

    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (s_tvalid && !s_acc) begin
            // hold the request
        end else if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            s_tvalid <= 1'b0;
        end else if (pending_q.size() == 0
                     || (sent_cnt == DRAIN_AT && hit_expect_q.size() != 0)) begin
            s_tvalid <= 1'b0;
        end else begin
            cur_seg = pending_q.pop_front();
            s_tdata <= {1'b0, cur_seg.radius, cur_seg.cz, cur_seg.cx,
                        cur_seg.dz, cur_seg.dx, cur_seg.oz, cur_seg.ox};
            s_tvalid <= 1'b1;
            sent_cnt <= sent_cnt + 1;
            if (burst_left <= 1) begin
                burst_left <= $urandom_range(1, 40);
                gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end else begin
                burst_left <= burst_left - 1;
            end
        end
    end

    // Receiver: stall patterns that change over time, plus one long hold-off.
    initial begin
        m_tready = 1'b0;
        stall_mode = 0;
        cycle_cnt = 0;
    end

    always @(negedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt % 97 == 0) stall_mode <= $urandom_range(0, 3);
        if (cycle_cnt >= HOLD_START && cycle_cnt < HOLD_START + HOLD_LEN) begin
            m_tready <= 1'b0;
        end else begin
            case (stall_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= ($urandom_range(0, 1) == 0);
                2:       m_tready <= ($urandom_range(0, 3) == 0);
                default: m_tready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    // Monitor: predict on request, compare on result, watch for a hang.
    always @(posedge aclk) begin
        result_t exp_r;
        segment_t acc_seg;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                acc_seg.ox = s_tdata[31:0];
                acc_seg.oz = s_tdata[63:32];
                acc_seg.dx = s_tdata[95:64];
                acc_seg.dz = s_tdata[127:96];
                acc_seg.cx = s_tdata[159:128];
                acc_seg.cz = s_tdata[191:160];
                acc_seg.radius = s_tdata[222:192];
                hit_expect_q.push_back(predict_hit(acc_seg));
            end
            if (m_tvalid && m_tready) begin
                if (hit_expect_q.size() == 0) begin
                    $error("result with no request outstanding");
                    errors++;
                end else begin
                    exp_r = hit_expect_q.pop_front();
                    if (m_tdata[0] !== exp_r.hit) begin
                        $error("hit: expected %0d got %0d", exp_r.hit, m_tdata[0]);
                        errors++;
                    end
                    if (m_tuser !== exp_r.status) begin
                        $error("status: expected %0d got %0d", exp_r.status, m_tuser);
                        errors++;
                    end
                    if (m_tdata[32:1] !== exp_r.root_plus) begin
                        $error("root_plus: expected %h got %h", exp_r.root_plus,
                               m_tdata[32:1]);
                        errors++;
                    end
                    if (m_tdata[64:33] !== exp_r.root_minus) begin
                        $error("root_minus: expected %h got %h", exp_r.root_minus,
                               m_tdata[64:33]);
                        errors++;
                    end
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cnt <= 0;
            end else if (!stim_done) begin
                idle_cnt <= idle_cnt + 1;
                if (idle_cnt >= IDLE_LIMIT) begin
                    $display("end of test: mismatches");
                    $finish;
                end
            end
        end else begin
            idle_cnt <= 0;
        end
    end

endmodule
